[rtl/rcru_pkg.sv]
// Package for the rectangle clip region unit: coordinate width, operation codes,
// and the rectangle, item and result slot types.
// Depends on nothing; every other file of the block imports it.
package rcru_pkg;

	localparam int COORD_WIDTH = 16;
	// Four difference strips plus rectangle B for a union.
	localparam int NUM_SLOTS   = 5;
	localparam int SLOT_W      = $clog2(NUM_SLOTS);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [1:0] {
		OP_INTERSECT = 2'd0,
		OP_DIFF      = 2'd1,
		OP_UNION     = 2'd2,
		OP_POINT     = 2'd3
	} op_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
	} rect_t;

	typedef struct packed {
		op_t    op;
		rect_t  a;
		rect_t  b;
		coord_t px;
		coord_t py;
	} item_t;

	typedef struct packed {
		rect_t rect;
		logic  region_valid;
		logic  hit;
	} slot_t;

endpackage

[rtl/rectangle_clip_region_unit.sv]
// Top level of the rectangle clip region unit: input register, evaluation and result buffer.
// Depends on rcru_pkg, rcru_compute and rcru_emitter.
//
// An accepted item is held in an input register, evaluated combinationally and loaded
// into a result buffer, from which its first result is presented. The block then sends
// one result per cycle while out_ready is high: one for intersect and point test, one to
// four for a difference (the empty outcome counts as one), one to five for a union, the
// final one marked with last. The result channel sets the throughput: the buffer takes the
// next item as its final result transfers, so a stream of intersects or point tests runs at
// one item per cycle while out_ready is high, and a stream of full unions is slowed by its
// five results. While the buffer drains, the next item is taken into the input register
// and waits there.
module rectangle_clip_region_unit import rcru_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [COORD_WIDTH-1:0] a_x0,
	input  logic [COORD_WIDTH-1:0] a_y0,
	input  logic [COORD_WIDTH-1:0] a_x1,
	input  logic [COORD_WIDTH-1:0] a_y1,
	input  logic [COORD_WIDTH-1:0] b_x0,
	input  logic [COORD_WIDTH-1:0] b_y0,
	input  logic [COORD_WIDTH-1:0] b_x1,
	input  logic [COORD_WIDTH-1:0] b_y1,
	input  logic [COORD_WIDTH-1:0] point_x,
	input  logic [COORD_WIDTH-1:0] point_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_WIDTH-1:0] r_x0,
	output logic [COORD_WIDTH-1:0] r_y0,
	output logic [COORD_WIDTH-1:0] r_x1,
	output logic [COORD_WIDTH-1:0] r_y1,
	output logic                   region_valid,
	output logic                   hit,
	output logic                   last
);

	logic                 valid_s1;
	item_t                item_s1;
	slot_t                slots [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] mask;
	logic                 emit_load;
	logic                 emit_free;
	slot_t                cur;
	logic                 in_take;

	assign in_take   = in_valid && in_ready;
	assign emit_load = valid_s1 && emit_free;
	assign in_ready  = !valid_s1 || emit_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op   <= op_t'(op);
			item_s1.a    <= '{x0: a_x0, y0: a_y0, x1: a_x1, y1: a_y1};
			item_s1.b    <= '{x0: b_x0, y0: b_y0, x1: b_x1, y1: b_y1};
			item_s1.px   <= point_x;
			item_s1.py   <= point_y;
		end
	end

	rcru_compute u_compute (
		.item  (item_s1),
		.slots (slots),
		.mask  (mask)
	);

	rcru_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.slots     (slots),
		.mask      (mask),
		.free      (emit_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cur       (cur),
		.cur_last  (last)
	);

	assign r_x0         = cur.rect.x0;
	assign r_y0         = cur.rect.y0;
	assign r_x1         = cur.rect.x1;
	assign r_y1         = cur.rect.y1;
	assign region_valid = cur.region_valid;
	assign hit          = cur.hit;

endmodule

[rtl/rcru_compute.sv]
// Combinational evaluation of one item: fills the result slots and their mask.
// Slots 0..3 hold the difference strips (top, bottom, left, right), slot 4 rectangle B.
// Depends on rcru_pkg.
module rcru_compute import rcru_pkg::*; (
	input  item_t                 item,
	output slot_t                 slots [NUM_SLOTS],
	output logic [NUM_SLOTS-1:0]  mask
);

	coord_t mx0, my0, nx1, my1;
	logic   overlap, equal, point_in;
	logic   a_wide;
	logic [NUM_SLOTS-1:0] raw_mask;
	slot_t  zero_slot;

	assign mx0 = (item.a.x0 > item.b.x0) ? item.a.x0 : item.b.x0;
	assign my0 = (item.a.y0 > item.b.y0) ? item.a.y0 : item.b.y0;
	assign nx1 = (item.a.x1 < item.b.x1) ? item.a.x1 : item.b.x1;
	assign my1 = (item.a.y1 < item.b.y1) ? item.a.y1 : item.b.y1;

	assign overlap  = (mx0 < nx1) && (my0 < my1);
	assign equal    = (item.a == item.b);
	assign a_wide   = item.a.x0 < item.a.x1;
	assign point_in = (item.a.x0 < item.px) && (item.px < item.a.x1) &&
	                  (item.a.y0 < item.py) && (item.py < item.a.y1);

	assign zero_slot = '{rect: '0, region_valid: 1'b0, hit: 1'b0};

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slots[i] = zero_slot;
		end
		raw_mask = '0;
		unique case (item.op)
			OP_INTERSECT: begin
				slots[0].rect         = '{x0: mx0, y0: my0, x1: nx1, y1: my1};
				slots[0].region_valid = 1'b1;
				slots[0].hit          = overlap;
				raw_mask[0]           = 1'b1;
			end
			OP_POINT: begin
				slots[0].hit = point_in;
				raw_mask[0]  = 1'b1;
			end
			OP_DIFF, OP_UNION: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					slots[i].region_valid = 1'b1;
				end
				slots[0].rect = '{x0: item.a.x0, y0: item.b.y1, x1: item.a.x1, y1: item.a.y1};
				slots[1].rect = '{x0: item.a.x0, y0: item.a.y0, x1: item.a.x1, y1: item.b.y0};
				slots[2].rect = '{x0: item.a.x0, y0: my0, x1: item.b.x0, y1: my1};
				slots[3].rect = '{x0: item.b.x1, y0: my0, x1: item.a.x1, y1: my1};
				slots[4].rect = item.b;
				if (!equal) begin
					if (!overlap) begin
						// Disjoint rectangles leave A whole.
						slots[0].rect = item.a;
						raw_mask[0]   = 1'b1;
					end else begin
						raw_mask[0] = (item.a.y0 < item.b.y1) && (item.b.y1 < item.a.y1) && a_wide;
						raw_mask[1] = (item.a.y0 < item.b.y0) && (item.b.y0 < item.a.y1) && a_wide;
						raw_mask[2] = (item.a.x0 < item.b.x0) && (item.b.x0 < item.a.x1) &&
						              (my0 < my1);
						raw_mask[3] = (item.a.x0 < item.b.x1) && (item.b.x1 < item.a.x1) &&
						              (my0 < my1);
					end
				end
				raw_mask[4] = (item.op == OP_UNION);
			end
			default: begin
				raw_mask = '0;
			end
		endcase
		// The empty fallback only arises for a difference, where slot 0 must read as zero.
		if (raw_mask == '0) begin
			slots[0] = zero_slot;
		end
	end

	// An operation that yields no rectangle still sends one empty result.
	always_comb begin
		mask = raw_mask;
		if (raw_mask == '0) begin
			mask[0] = 1'b1;
		end
	end

endmodule

[rtl/rcru_emitter.sv]
// Result buffer: holds the slots of one item and sends the pending ones in order,
// one transfer per cycle on the result channel while out_ready is high. Depends on rcru_pkg.
module rcru_emitter import rcru_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  slot_t                 slots [NUM_SLOTS],
	input  logic [NUM_SLOTS-1:0]  mask,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output slot_t                 cur,
	output logic                  cur_last
);

	logic [NUM_SLOTS-1:0] pend_q;
	slot_t                slots_q [NUM_SLOTS];
	logic [SLOT_W-1:0]    sel;
	logic [NUM_SLOTS-1:0] rest;
	logic                 take;

	// Lowest pending slot goes first.
	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			rest[i] = pend_q[i] && (SLOT_W'(i) != sel);
		end
	end

	assign out_valid = |pend_q;
	assign take      = out_valid && out_ready;
	assign cur_last  = (rest == '0);
	assign free      = !out_valid || (take && cur_last);
	assign cur       = slots_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= mask;
		end else if (take) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slots_q[i] <= slots[i];
			end
		end
	end

endmodule
